FILE: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Field widths, character codes, opcodes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   localparam int OPCODE_W  = 1;
   localparam int CHAR_W    = 8;
   localparam int ADDRESS_W = 11;
   localparam int CELL_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int COLOR_W   = 8;

   localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } tcw_state_type;

   typedef struct packed {
      logic capture;   // latch the request fields
      logic step;      // execute the latched request
      logic clear;     // reset sweep: write one blank cell
      logic scroll;    // scroll sweep: copy or blank one cell
      logic load_rsp;  // load the response register
   } tcw_cmd_type;

   typedef struct packed {
      logic ptr_last;  // sweep pointer at last cell
      logic wrap;      // current put runs past the last row
      logic rsp_free;  // response register can take a new transaction
   } tcw_status_type;

endpackage

FILE: sv/tcw_channels.sv
// ----------------------------------------------------------------------------
// tcw channels: request, response and CSR write channel interfaces
// Each carries valid, ready and its payload, with source and sink modports.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [CHAR_W-1:0]    char_code;
   logic [ADDRESS_W-1:0] cell_address;
   modport source (output valid, opcode, char_code, cell_address, input ready);
   modport sink   (input valid, opcode, char_code, cell_address, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CELL_W-1:0]    read_data;
   logic [ROW_OUT_W-1:0] cursor_row;
   logic [COL_OUT_W-1:0] cursor_column;
   logic                 scrolled;
   modport source (output valid, read_data, cursor_row, cursor_column, scrolled,
                   input ready);
   modport sink   (input valid, read_data, cursor_row, cursor_column, scrolled,
                   output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] text_color;
   modport source (output valid, text_color, input ready);
   modport sink   (input valid, text_color, output ready);
endinterface

FILE: sv/tcw_controller.sv
// ----------------------------------------------------------------------------
// tcw_controller: sequencing state machine
// Runs the reset clearing sweep, accepts one request, executes it, runs the
// scroll sweep when needed and hands the result to the response register.
// ----------------------------------------------------------------------------
module tcw_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   tcw_state_type state_ff;
   tcw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.ptr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.wrap ? ST_SCROLL : ST_DONE;
         end
         ST_SCROLL: begin
            if (status.ptr_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.step = 1'b1;
         end
         ST_SCROLL: begin
            cmd.scroll = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: screen memory, cursor and response register
// One write port fed by a registered write stage, one registered read port.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::tcw_cmd_type              cmd,
   output tcw_pkg::tcw_status_type           status,
   input  logic [tcw_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::ADDRESS_W-1:0]     req_cell_address,
   input  logic                              csr_write,
   input  logic [tcw_pkg::COLOR_W-1:0]       csr_text_color,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_read_data,
   output logic [tcw_pkg::ROW_OUT_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]     rsp_cursor_column,
   output logic                              rsp_scrolled
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);

   // latched request
   logic [OPCODE_W-1:0]  op_ff;
   logic [CHAR_W-1:0]    ch_ff;
   logic [ADDRESS_W-1:0] addr_ff;

   logic [COLOR_W-1:0] color_ff;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  ptr_ff;
   logic               scrolled_ff;

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   logic              wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] wr_data_ff, wr_data_in;
   logic              wr_copy_ff, wr_copy_in;

   logic                 rsp_valid_ff;
   logic [CELL_W-1:0]    rsp_data_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic                 rsp_scrolled_ff;

   logic              is_put, is_newline, in_range, copy_phase;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic              row_adv, wrap;
   logic [ADDR_W-1:0] put_idx;
   logic [31:0]       addr_wide, row_wide, col_wide;
   logic [CELL_W-1:0] read_value;

   assign is_put     = (op_ff == OP_PUT);
   assign is_newline = (ch_ff == NEWLINE_CODE);
   assign addr_wide  = 32'(addr_ff);
   assign in_range   = (addr_wide < 32'(CELL_COUNT));
   assign copy_phase = (32'(ptr_ff) < 32'(COPY_COUNT));

   // cursor advance for a put
   assign col_inc = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_inc = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign row_adv = is_newline || (col_inc == (COL_W+1)'(COLUMNS));
   assign wrap    = row_adv && (row_inc == (ROW_W+1)'(ROWS));

   always_comb begin
      col_in = (row_adv) ? '0 : col_inc[COL_W-1:0];
      // on wrap the row is already the last one and stays there
      row_in = (row_adv && !wrap) ? row_inc[ROW_W-1:0] : row_ff;
   end

   assign put_idx = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   assign status.ptr_last = (ptr_ff == ADDR_W'(CELL_COUNT - 1));
   assign status.wrap     = is_put && wrap;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // read port
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff + ADDR_W'(COLUMNS);
      if (cmd.step && !is_put && in_range) begin
         rd_en   = 1'b1;
         rd_addr = addr_wide[ADDR_W-1:0];
      end else if (cmd.scroll && copy_phase) begin
         rd_en = 1'b1;
      end
   end

   // write stage: every memory write is registered and lands in the cycle after it is issued
   always_comb begin
      wr_valid_in = cmd.clear || cmd.scroll || (cmd.step && is_put && !is_newline);
      wr_addr_in  = ptr_ff;
      wr_data_in  = {color_ff, SPACE_CODE};
      wr_copy_in  = cmd.scroll && copy_phase;
      if (cmd.clear) begin
         wr_data_in = RESET_CELL;
      end else if (cmd.step) begin
         wr_addr_in = put_idx;
         wr_data_in = {color_ff, ch_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_valid_ff) mem[wr_addr_ff] <= wr_copy_ff ? rd_data_ff : wr_data_ff;
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      wr_copy_ff <= wr_copy_in;
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         ch_ff   <= req_char_code;
         addr_ff <= req_cell_address;
      end
      if (cmd.step) scrolled_ff <= status.wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
         color_ff    <= RESET_COLOR;
         row_ff      <= '0;
         col_ff      <= '0;
         ptr_ff      <= '0;
      end else begin
         wr_valid_ff <= wr_valid_in;
         if (csr_write) color_ff <= csr_text_color;
         if (cmd.step && is_put) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (cmd.clear || cmd.scroll) begin
            ptr_ff <= status.ptr_last ? '0 : ptr_ff + ADDR_W'(1);
         end
      end
   end

   // response register
   assign row_wide   = 32'(row_ff);
   assign col_wide   = 32'(col_ff);
   assign read_value = (!is_put && in_range) ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff     <= read_value;
         rsp_row_ff      <= row_wide[ROW_OUT_W-1:0];
         rsp_col_ff      <= col_wide[COL_OUT_W-1:0];
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

endmodule

FILE: sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cursor and scrolling
// Top level joining the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  carries one request transaction: a put (opcode 0) writes
//             char_code at the cursor in the current color and advances it,
//             newline (10) moves to column 0 of the next row; a read
//             (opcode 1) returns the cell at cell_address.
//   rsp_chan  returns one transaction per request: read_data (0 for puts and
//             for addresses past the screen), the cursor and a scroll flag.
//   csr_chan  writes text_color; always ready. Write it only while idle.
// Timing:
//   rsp_chan.valid rises once the request has passed execute (one memory
//   access) and then the load of the response register. The controller is
//   back in idle after the load, so it takes a new request only after that load.
//   A put that runs past the last row scrolls one cell per cycle (copy up,
//   then blank the last row), set by the single write port of the screen
//   memory.
// Reset:
//   Cursor goes to 0,0 and color to 7. A clearing sweep then writes every
//   cell to a grey space, with req_chan.ready held low.
// Stall:
//   A finished response waits in its register; the next request is still
//   accepted and runs up to its response load, where it holds until free.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
   input logic      clock,
   input logic      reset,
   tcw_req_if.sink  req_chan,
   tcw_rsp_if.source rsp_chan,
   tcw_csr_if.sink  csr_chan
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   // color register is always free to take a write
   assign csr_chan.ready = 1'b1;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_chan.opcode),
      .req_char_code     (req_chan.char_code),
      .req_cell_address  (req_chan.cell_address),
      .csr_write         (csr_chan.valid),
      .csr_text_color    (csr_chan.text_color),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_read_data     (rsp_chan.read_data),
      .rsp_cursor_row    (rsp_chan.cursor_row),
      .rsp_cursor_column (rsp_chan.cursor_column),
      .rsp_scrolled      (rsp_chan.scrolled)
   );

endmodule

FILE: sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for text_console_writer
// Response handshake, scroll cursor position and the post-reset clear.
// ----------------------------------------------------------------------------
module tcw_checker #(
   parameter int ROWS = tcw_pkg::DEFAULT_ROWS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tcw_pkg::CELL_W-1:0]    rsp_read_data,
   input logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row,
   input logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_column,
   input logic                          rsp_scrolled
);
   import tcw_pkg::*;

   localparam logic [31:0] LAST_ROW = 32'(ROWS - 1);
   localparam logic [ROW_OUT_W-1:0] LAST_ROW_OUT = LAST_ROW[ROW_OUT_W-1:0];

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_cursor_row)
         && $stable(rsp_cursor_column) && $stable(rsp_scrolled))
      else $error("stalled response changed");

   // a scroll always leaves the cursor at the start of the last row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_column == '0
         && rsp_cursor_row == LAST_ROW_OUT)
      else $error("scroll left cursor off the last row start");

   // clearing sweep holds off requests right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready && !rsp_valid)
      else $error("request taken during clearing sweep");

endmodule

bind text_console_writer tcw_checker #(.ROWS(ROWS)) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_read_data     (rsp_chan.read_data),
   .rsp_cursor_row    (rsp_chan.cursor_row),
   .rsp_cursor_column (rsp_chan.cursor_column),
   .rsp_scrolled      (rsp_chan.scrolled)
);

FILE: verif/text_console_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking bench for the text console writer
// Drives put and read transactions, tracks the screen and cursor in a local
// copy, and compares every response field by field. A short table of fixed
// transactions is followed by random text runs, newline bursts, read-backs and
// noise, in phases that each set a new text color and idle pattern.
// ----------------------------------------------------------------------------
module text_console_writer_test;
   import tcw_pkg::*;

   localparam int COLUMNS = DEFAULT_COLUMNS;
   localparam int ROWS    = DEFAULT_ROWS;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDRESS_TOP = (1 << ADDRESS_W) - 1;

   localparam int IDLE_CAP          = 17;
   localparam int PHASE_COUNT       = 6;
   localparam int PHASE_ITEMS       = 222;
   localparam int HOLD_PHASE        = 3;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int SETTLE_CYCLES     = 40;
   // Worst case: every transaction scrolls and waits out both idle caps.
   localparam int LIMIT_CYCLES =
      3 * ((PHASE_COUNT * PHASE_ITEMS + 200) * (CELLS + 2 * IDLE_CAP + 8)
           + CELLS + LONG_STALL_CYCLES);

   typedef struct packed {
      logic [CELL_W-1:0]    read_data;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_column;
      logic                 scrolled;
   } console_result_type;

   typedef struct {
      logic [OPCODE_W-1:0]  opcode;
      logic [CHAR_W-1:0]    char_code;
      logic [ADDRESS_W-1:0] cell_address;
      bit                   typed;
      console_result_type   result;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 19;

   // Fixed opening transactions. Rows marked typed carry their response
   // literally; the rest take the response from the screen tracker.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_READ, 8'h00, 11'd0,    1'b1, {RESET_CELL, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'hFF, 11'd1999, 1'b1, {RESET_CELL, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'h00, 11'd2000, 1'b1, {16'h0000,   5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'h55, 11'd2047, 1'b1, {16'h0000,   5'd0, 7'd0, 1'b0}},
      '{OP_PUT,  8'h41, 11'd0,    1'b1, {16'h0000,   5'd0, 7'd1, 1'b0}},
      '{OP_PUT,  8'h00, 11'd0,    1'b1, {16'h0000,   5'd0, 7'd2, 1'b0}},
      '{OP_PUT,  8'hFF, 11'd0,    1'b1, {16'h0000,   5'd0, 7'd3, 1'b0}},
      '{OP_PUT,  8'h80, 11'd1365, 1'b1, {16'h0000,   5'd0, 7'd4, 1'b0}},
      '{OP_PUT,  8'h7F, 11'd2047, 1'b1, {16'h0000,   5'd0, 7'd5, 1'b0}},
      '{OP_READ, 8'h00, 11'd0,    1'b1, {16'h0741,   5'd0, 7'd5, 1'b0}},
      '{OP_READ, 8'h00, 11'd1,    1'b1, {16'h0700,   5'd0, 7'd5, 1'b0}},
      '{OP_READ, 8'h00, 11'd2,    1'b1, {16'h07FF,   5'd0, 7'd5, 1'b0}},
      '{OP_READ, 8'h00, 11'd3,    1'b1, {16'h0780,   5'd0, 7'd5, 1'b0}},
      '{OP_READ, NEWLINE_CODE, 11'd4, 1'b1, {16'h077F, 5'd0, 7'd5, 1'b0}},
      '{OP_PUT,  NEWLINE_CODE, 11'd0, 1'b1, {16'h0000, 5'd1, 7'd0, 1'b0}},
      '{OP_PUT,  NEWLINE_CODE, 11'd682, 1'b1, {16'h0000, 5'd2, 7'd0, 1'b0}},
      '{OP_PUT,  SPACE_CODE, 11'd0, 1'b0, '0},
      '{OP_READ, 8'hAA, 11'd160,  1'b0, '0},
      '{OP_READ, 8'h00, 11'd1024, 1'b0, '0}
   };

   localparam logic [COLOR_W-1:0] PHASE_COLORS [PHASE_COUNT] =
      '{8'hFF, 8'h00, 8'h1E, RESET_COLOR, 8'hA5, 8'h5A};
   localparam int REQ_IDLE_CAPS [PHASE_COUNT] = '{17, 0, 17, 0, 17, 5};
   localparam int RSP_IDLE_CAPS [PHASE_COUNT] = '{17, 0, 0, 17, 17, 5};

   logic clock;
   logic reset;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();
   tcw_csr_if csr_chan ();

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Screen tracker: local copy of the cells, cursor and text color.
   logic [CELL_W-1:0]  screen_copy [CELLS];
   int                 cursor_row_now;
   int                 cursor_col_now;
   logic [COLOR_W-1:0] color_now;

   console_result_type pending_results [$];

   int req_idle_max;
   int rsp_idle_max;
   int rsp_hold;
   int long_stall_request;

   int mismatch_count;
   int accepted_total;
   int put_total;
   int newline_total;
   int read_total;
   int past_screen_total;
   int scroll_total;
   int color_writes;
   int result_total;

   // Free-running clock, 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: no correct run gets anywhere near this.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("%0t ns: timeout, %0d responses still pending", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // Apply one transaction to the screen tracker and return its response.
   function automatic console_result_type advance_console(
      input logic [OPCODE_W-1:0]  op,
      input logic [CHAR_W-1:0]    ch,
      input logic [ADDRESS_W-1:0] addr
   );
      console_result_type res;
      int                 k;
      res = '0;
      if (op == OP_READ) begin
         if (addr < CELLS) res.read_data = screen_copy[addr];
      end else begin
         if (ch == NEWLINE_CODE) begin
            cursor_col_now = 0;
            cursor_row_now++;
         end else begin
            screen_copy[cursor_row_now * COLUMNS + cursor_col_now] = {color_now, ch};
            cursor_col_now++;
         end
         // Wrap past the last column, then scroll past the last row.
         if (cursor_col_now >= COLUMNS) begin
            cursor_col_now = 0;
            cursor_row_now++;
         end
         if (cursor_row_now >= ROWS) begin
            for (k = 0; k < CELLS - COLUMNS; k++) screen_copy[k] = screen_copy[k + COLUMNS];
            for (k = CELLS - COLUMNS; k < CELLS; k++) screen_copy[k] = {color_now, SPACE_CODE};
            cursor_row_now = ROWS - 1;
            res.scrolled   = 1'b1;
            scroll_total++;
         end
      end
      res.cursor_row    = cursor_row_now[ROW_OUT_W-1:0];
      res.cursor_column = cursor_col_now[COL_OUT_W-1:0];
      return res;
   endfunction

   // Offer one request transaction after a random gap and hold it until
   // accepted. Leave valid high so a back-to-back transaction needs no drop.
   task automatic send_request(
      input logic [OPCODE_W-1:0]  op,
      input logic [CHAR_W-1:0]    ch,
      input logic [ADDRESS_W-1:0] addr,
      input bit                   typed,
      input console_result_type   literal
   );
      int                 gap;
      console_result_type want;
      gap = $urandom_range(0, req_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.opcode       = op;
      req_chan.char_code    = ch;
      req_chan.cell_address = addr;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = advance_console(op, ch, addr);
      if (typed) want = literal;
      pending_results.push_back(want);
      accepted_total++;
      if (op == OP_READ) begin
         read_total++;
         if (addr >= CELLS) past_screen_total++;
      end else begin
         put_total++;
         if (ch == NEWLINE_CODE) newline_total++;
      end
   endtask

   // Drop the request valid and wait until every response is back.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write the text color register while the block is idle.
   task automatic write_text_color(input logic [COLOR_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_chan.valid      = 1'b1;
      csr_chan.text_color = value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      color_now = value;
      color_writes++;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Mostly printable text, with newlines, zero bytes and high bytes mixed in.
   function automatic logic [CHAR_W-1:0] pick_char();
      case ($urandom_range(0, 19))
         0:       return NEWLINE_CODE;
         1:       return 8'h00;
         2, 3:    return 8'($urandom_range(128, 255));
         4, 5:    return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // Read addresses: anywhere, near the cursor, the bottom row, or past the end.
   function automatic logic [ADDRESS_W-1:0] pick_address();
      case ($urandom_range(0, 7))
         0:       return 11'($urandom_range(CELLS, ADDRESS_TOP));
         1:       return 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
         2, 3:    return 11'(cursor_row_now * COLUMNS + $urandom_range(0, COLUMNS - 1));
         default: return 11'($urandom_range(0, CELLS - 1));
      endcase
   endfunction

   // One random sequence: a text run, reads, a newline burst, a row
   // read-back or plain noise.
   task automatic run_random_sequence();
      int kind;
      int count;
      int base;
      int k;
      kind = $urandom_range(0, 9);
      case (kind)
         4, 5: begin
            count = $urandom_range(1, 8);
            repeat (count)
               send_request(OP_READ, 8'($urandom_range(0, 255)), pick_address(), 1'b0, '0);
         end
         6: begin
            count = $urandom_range(1, 30);
            repeat (count)
               send_request(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, ADDRESS_TOP)),
                            1'b0, '0);
         end
         7: begin
            count = $urandom_range(1, 10);
            repeat (count)
               send_request(($urandom_range(0, 1) == 0) ? OP_PUT : OP_READ,
                            8'($urandom_range(0, 255)),
                            11'($urandom_range(0, ADDRESS_TOP)), 1'b0, '0);
         end
         8: begin
            base  = cursor_row_now * COLUMNS;
            count = $urandom_range(1, 16);
            for (k = 0; k < count; k++)
               send_request(OP_READ, 8'($urandom_range(0, 255)), 11'(base + k), 1'b0, '0);
         end
         default: begin
            count = $urandom_range(1, 100);
            repeat (count)
               send_request(OP_PUT, pick_char(), 11'($urandom_range(0, ADDRESS_TOP)),
                            1'b0, '0);
         end
      endcase
   endtask

   function automatic void compare_field(
      input string             field,
      input logic [CELL_W-1:0] want,
      input logic [CELL_W-1:0] got
   );
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // Response checker: pop the oldest expectation on every accepted response
   // transaction, then draw the idle time before the next one is taken.
   always @(posedge clock) begin
      console_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_total++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected response, expected none, actual %0h/%0d/%0d/%0b",
                     $time, rsp_chan.read_data, rsp_chan.cursor_row,
                     rsp_chan.cursor_column, rsp_chan.scrolled);
         end else begin
            want = pending_results.pop_front();
            compare_field("read_data", want.read_data, rsp_chan.read_data);
            compare_field("cursor_row", 16'(want.cursor_row), 16'(rsp_chan.cursor_row));
            compare_field("cursor_column", 16'(want.cursor_column),
                          16'(rsp_chan.cursor_column));
            compare_field("scrolled", 16'(want.scrolled), 16'(rsp_chan.scrolled));
         end
         rsp_hold = $urandom_range(0, rsp_idle_max);
      end
   end

   // Response ready: hold low for the drawn idle time, or for a long stall
   // when one is requested, otherwise keep it high.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_request > 0) begin
            rsp_hold           = long_stall_request;
            long_stall_request = 0;
         end
         if (rsp_hold > 0) begin
            rsp_chan.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Main stimulus.
   initial begin
      int row;
      int phase;
      int phase_start;
      int k;

      // Drive every input to a known value and hold reset.
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = OP_PUT;
      req_chan.char_code    = '0;
      req_chan.cell_address = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.text_color   = '0;
      for (k = 0; k < CELLS; k++) screen_copy[k] = RESET_CELL;
      cursor_row_now     = 0;
      cursor_col_now     = 0;
      color_now          = RESET_COLOR;
      req_idle_max       = IDLE_CAP;
      rsp_idle_max       = IDLE_CAP;
      rsp_hold           = 0;
      long_stall_request = 0;
      mismatch_count     = 0;
      accepted_total     = 0;
      put_total          = 0;
      newline_total      = 0;
      read_total         = 0;
      past_screen_total  = 0;
      scroll_total       = 0;
      color_writes       = 0;
      result_total       = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Walk the fixed table; the first transaction also waits out the
      // clearing sweep, since ready stays low until it is done.
      for (row = 0; row < DIRECTED_COUNT; row++)
         send_request(directed_rows[row].opcode, directed_rows[row].char_code,
                      directed_rows[row].cell_address, directed_rows[row].typed,
                      directed_rows[row].result);

      // Random phases: new color (both extremes included), new idle caps.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT - 1)
            write_text_color(8'($urandom_range(0, 255)));
         else
            write_text_color(PHASE_COLORS[phase]);
         req_idle_max = REQ_IDLE_CAPS[phase];
         rsp_idle_max = RSP_IDLE_CAPS[phase];
         // Stall the responses for a long stretch while requests keep coming.
         if (phase == HOLD_PHASE) long_stall_request = LONG_STALL_CYCLES;
         phase_start = accepted_total;
         while (accepted_total - phase_start < PHASE_ITEMS) begin
            run_random_sequence();
            // Now and then pause until every response is back.
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d puts (%0d newlines), %0d reads (%0d past the screen), %0d scrolls",
               put_total, newline_total, read_total, past_screen_total, scroll_total);
      $display("over %0d responses and %0d text color settings; %0d mismatches",
               result_total, color_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
